[sv/tsss_pkg.sv]
// Shared types and constants for the typestate set step unit.
package tsss_pkg;

  localparam int SET_W       = 16;
  localparam int STATE_W     = 4;
  localparam int METHOD_W    = 4;
  localparam int NUM_LANES   = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  typedef struct packed {
    logic                clear;
    logic                rd_en;
    logic                member;
    logic                meth_ok;
    logic [METHOD_W-1:0] method;
    logic                wr_en;
    logic [METHOD_W-1:0] wr_method;
    logic [STATE_W-1:0]  wr_next;
  } lane_cmd_t;

  typedef struct packed {
    logic [SET_W-1:0] next_set;
    logic             err;
  } lane_res_t;

endpackage

[sv/tsss_lane.sv]
// One lane: a bank of the transition table and the accumulator for its states.
module tsss_lane
  import tsss_pkg::*;
#(
  parameter int ROWS = 8,
  parameter int SPAN = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lane_cmd_t                           cmd,
  input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] rd_row,
  input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] wr_row,
  output lane_res_t                           res
);

  localparam int DEPTH  = ROWS * SPAN;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [STATE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   valid_r;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic [STATE_W-1:0] rd_data_r;
  logic               rd_valid_r;
  logic               hit_q_r;
  logic               meth_ok_q_r;
  logic [SET_W-1:0]   acc_r;
  logic               err_r;

  assign rd_addr = ADDR_W'(int'(rd_row) * SPAN + int'(cmd.method));
  assign wr_addr = ADDR_W'(int'(wr_row) * SPAN + int'(cmd.wr_method));

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= cmd.wr_next;
    end
    rd_data_r  <= mem[rd_addr];
    rd_valid_r <= valid_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      hit_q_r     <= 1'b0;
      meth_ok_q_r <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      hit_q_r     <= cmd.rd_en && cmd.member;
      meth_ok_q_r <= cmd.meth_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      acc_r <= '0;
      err_r <= 1'b0;
    end else if (hit_q_r) begin
      if (meth_ok_q_r && rd_valid_r) begin
        acc_r <= acc_r | (SET_W'(1) << rd_data_r);
      end else begin
        err_r <= 1'b1;
      end
    end
  end

  assign res.next_set = acc_r;
  assign res.err      = err_r;

endmodule

[sv/tsss_merge.sv]
// Merge stage: ORs the lane results into one registered result.
module tsss_merge
  import tsss_pkg::*;
(
  input  logic      clk,
  input  logic      capture,
  input  lane_res_t lane_res [NUM_LANES],
  output lane_res_t merged_r
);

  lane_res_t merged_nxt;

  always_comb begin
    merged_nxt = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      merged_nxt.next_set = merged_nxt.next_set | lane_res[i].next_set;
      merged_nxt.err      = merged_nxt.err | lane_res[i].err;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      merged_r <= merged_nxt;
    end
  end

endmodule

[sv/typestate_set_step_unit.sv]
// Top level of the typestate set step unit.
// Usage:
//   Input stream in_*: in_tuser selects the item kind (0 = step, 1 = load entry).
//   A load writes one (state, method) -> next state entry; a step maps the
//   state set through the table for one method and flags members that lack
//   an entry. Every item gives exactly one result item on out_*.
//   Sequence: a load passes ST_MERGE and ST_FINISH into the output register; a
//   step first scans the table banks in ST_SCAN, two states per cycle, one per
//   lane, then passes ST_DRAIN, ST_MERGE and ST_FINISH.
//   Throughput: one item at a time; in_tready is high only while no item is
//   in work, and an item leaves ST_FINISH only once the output register is
//   free. A result waiting in the output register does not block the next
//   item from being taken; only its final hand-over waits for out_tready.
//   Reset: every table entry is invalid, no item in work, out_tvalid low.
//   A stall on out_tready holds out_tdata and out_tvalid unchanged.
module typestate_set_step_unit
  import tsss_pkg::*;
#(
  parameter int NUM_STATES  = 16,
  parameter int NUM_METHODS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [15:0] state_set, [19:16] method, [23:20] from_state, [27:24] to_state
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] cmd
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [15:0] next_set, [16] error
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int SCAN_STATES  = (NUM_STATES < SET_W) ? NUM_STATES : SET_W;
  localparam int SPAN_METHODS = (NUM_METHODS < (1 << METHOD_W)) ? NUM_METHODS
                                                                : (1 << METHOD_W);
  localparam int ROWS  = (SCAN_STATES + NUM_LANES - 1) / NUM_LANES;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [SET_W:0]   ONE_EXT  = 1;
  localparam logic [SET_W-1:0] SET_MASK = SET_W'((ONE_EXT << SCAN_STATES) - ONE_EXT);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_MERGE  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [SET_W-1:0]    in_set;
  logic [METHOD_W-1:0] in_method;
  logic [STATE_W-1:0]  in_from;
  logic [STATE_W-1:0]  in_to;
  logic                in_fire;
  logic                out_free;
  logic                load_ok;
  logic [ROW_W-1:0]    wr_row;

  logic [2:0]          state_r, state_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [SET_W-1:0]    set_r, set_nxt;
  logic [METHOD_W-1:0] method_r;
  logic                meth_ok_r;
  logic                out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  lane_cmd_t lane_cmd [NUM_LANES];
  lane_res_t lane_res [NUM_LANES];
  lane_res_t merged_r;

  assign in_set    = in_tdata[15:0];
  assign in_method = in_tdata[19:16];
  assign in_from   = in_tdata[23:20];
  assign in_to     = in_tdata[27:24];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign load_ok   = (32'(in_from) < NUM_STATES) && (32'(in_method) < NUM_METHODS) &&
                     (32'(in_to) < NUM_STATES);
  assign wr_row    = ROW_W'(in_from / NUM_LANES);

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    set_nxt   = set_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          row_nxt   = '0;
          set_nxt   = in_set & SET_MASK;
          state_nxt = in_tuser ? ST_MERGE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        set_nxt = set_r >> NUM_LANES;
        if (row_r == ROW_W'(ROWS - 1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end
      ST_DRAIN:  state_nxt = ST_MERGE;
      ST_MERGE:  state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    set_r <= set_nxt;
    if (in_fire) begin
      method_r  <= in_method;
      meth_ok_r <= (32'(in_method) < NUM_METHODS);
    end
    if (state_r == ST_FINISH && out_free) begin
      out_data_r <= {{(OUT_TDATA_W - SET_W - 1){1'b0}}, merged_r.err, merged_r.next_set};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    always_comb begin
      lane_cmd[l].clear     = in_fire;
      lane_cmd[l].rd_en     = (state_r == ST_SCAN);
      lane_cmd[l].member    = set_r[l];
      lane_cmd[l].meth_ok   = meth_ok_r;
      lane_cmd[l].method    = method_r;
      lane_cmd[l].wr_en     = in_fire && in_tuser && load_ok &&
                              (32'(in_from % NUM_LANES) == l);
      lane_cmd[l].wr_method = in_method;
      lane_cmd[l].wr_next   = in_to;
    end

    tsss_lane #(
      .ROWS (ROWS),
      .SPAN (SPAN_METHODS)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (lane_cmd[l]),
      .rd_row (row_r),
      .wr_row (wr_row),
      .res    (lane_res[l])
    );
  end

  tsss_merge u_merge (
    .clk      (clk),
    .capture  (state_r == ST_MERGE),
    .lane_res (lane_res),
    .merged_r (merged_r)
  );

  a_finish_hands_over: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished result not handed to output register");

  a_step_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_tuser) |=> (state_r == ST_SCAN && row_r == '0))
    else $error("step item did not start the table scan");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && row_r == ROW_W'(ROWS - 1)) |=> (state_r == ST_DRAIN))
    else $error("scan overran the last row");

endmodule
